/* sv/ksf_pkg.sv */
// Package with the shared types, constants and register codes of the knob smoothing filter.
package ksf_pkg;

    localparam int KNOB_COUNT = 16;
    localparam int IDX_W = 4;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W = 8;
    localparam int VALUE_W = 7;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int ACTIVE_W = 5;

    localparam int RAW_TOP_INT = 130;
    localparam int SAMPLE_SPAN = 3800;
    localparam int SCALE_GCD = 10;
    localparam int SPAN_DIV = SAMPLE_SPAN / SCALE_GCD;
    localparam int TOP_MUL = RAW_TOP_INT / SCALE_GCD;
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_MUL = ((2 ** RECIP_SHIFT + SPAN_DIV - 1) / SPAN_DIV) * TOP_MUL;
    localparam int PROD_W = 33;

    localparam logic [LEVEL_W-1:0] RAW_TOP = LEVEL_W'(RAW_TOP_INT);
    localparam logic [SAMPLE_W-1:0] SAMPLE_LOW = SAMPLE_W'(100);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(133);
    localparam logic [LEVEL_W-1:0] VALUE_MAX = LEVEL_W'(127);

    localparam logic [7:0] ALPHA_RESET = 8'd64;
    localparam logic [7:0] DELTA_RESET = 8'd10;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_DELTA  = 2'd1,
        CFG_ACTIVE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]          alpha_q;
        logic [7:0]          jump_delta;
        logic [ACTIVE_W-1:0] active_knobs;
    } cfg_t;

endpackage

/* sv/ksf_stream_if.sv */
// Request channel interfaces for the sample input and the result output.
interface ksf_in_if;
    logic                          valid;
    logic                          ready;
    logic [ksf_pkg::IDX_W-1:0]     knob_index;
    logic [ksf_pkg::SAMPLE_W-1:0]  adc_sample;

    modport source (output valid, output knob_index, output adc_sample, input ready);
    modport sink (input valid, input knob_index, input adc_sample, output ready);
endinterface

interface ksf_out_if;
    logic                          valid;
    logic                          ready;
    logic [ksf_pkg::IDX_W-1:0]     knob_out;
    logic [ksf_pkg::VALUE_W-1:0]   knob_value;
    logic                          index_error;

    modport source (output valid, output knob_out, output knob_value, output index_error,
                    input ready);
    modport sink (input valid, input knob_out, input knob_value, input index_error,
                  output ready);
endinterface

/* sv/ksf_raw_map.sv */
// Inverse mapping of an ADC sample to a raw knob level by reciprocal multiplication.
module ksf_raw_map
(
    input  logic [ksf_pkg::SAMPLE_W-1:0] adc_sample,
    output logic [ksf_pkg::LEVEL_W-1:0]  raw
);

    logic [ksf_pkg::SAMPLE_W:0]   offset;
    logic [ksf_pkg::SAMPLE_W-1:0] mag;
    logic [ksf_pkg::PROD_W-1:0]   prod;
    logic [ksf_pkg::LEVEL_W-1:0]  quot;

    always_comb
    begin
        offset = {1'b0, adc_sample} - {1'b0, ksf_pkg::SAMPLE_LOW};
        mag = offset[ksf_pkg::SAMPLE_W] ? ksf_pkg::SAMPLE_W'(-offset)
                                        : offset[ksf_pkg::SAMPLE_W-1:0];
        prod = ksf_pkg::PROD_W'(mag) * ksf_pkg::PROD_W'(ksf_pkg::RECIP_MUL);
        quot = prod[ksf_pkg::RECIP_SHIFT+ksf_pkg::LEVEL_W-1:ksf_pkg::RECIP_SHIFT];
        priority if (offset[ksf_pkg::SAMPLE_W])
        begin
            raw = ksf_pkg::RAW_TOP + quot;
        end
        else if (quot > ksf_pkg::RAW_TOP)
        begin
            raw = '0;
        end
        else
        begin
            raw = ksf_pkg::RAW_TOP - quot;
        end
    end

endmodule

/* sv/ksf_level_update.sv */
// Per-knob level update: first load, jump bypass or exponential moving average step.
module ksf_level_update
(
    input  ksf_pkg::cfg_t                cfg,
    input  logic                         seen,
    input  logic [ksf_pkg::LEVEL_W-1:0]  raw,
    input  logic [ksf_pkg::LEVEL_W-1:0]  old,
    output logic [ksf_pkg::LEVEL_W-1:0]  level
);

    logic signed [8:0]  diff;
    logic [7:0]         abs_diff;
    logic signed [17:0] alpha_s;
    logic signed [17:0] prod;
    logic signed [9:0]  step;
    logic signed [9:0]  sum;

    always_comb
    begin
        diff = $signed({1'b0, raw}) - $signed({1'b0, old});
        abs_diff = diff[8] ? 8'(-diff) : diff[7:0];
        alpha_s = $signed({10'b0, cfg.alpha_q});
        prod = alpha_s * 18'(diff);
        step = 10'(prod >>> 8);
        sum = $signed({2'b0, old}) + step;
        priority if (!seen)
        begin
            level = raw;
        end
        else if (abs_diff > cfg.jump_delta)
        begin
            level = raw;
        end
        else if (abs_diff != 8'd0)
        begin
            level = sum[ksf_pkg::LEVEL_W-1:0];
        end
        else
        begin
            level = old;
        end
    end

endmodule

/* sv/ksf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ksf_ram
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/knob_scan_smoothing_filter_core.sv */
// Top level of the knob scan smoothing filter.
// Usage: each request on sample_ch carries a knob index and a 12-bit ADC sample.
// Every accepted request gives exactly one request on result_ch with the index
// echoed, the smoothed level clamped to 127 and an index error flag.
// An index at or above active_knobs returns value zero with the error flag set
// and leaves all state untouched.
// An accepted sample goes to the read stage, then to the output register.
// Throughput: one sample per cycle while result_ch is ready, set by the
// read-modify-write of the per-knob level RAM, with the level just written
// forwarded to the next read.
// The configuration port writes alpha_q, jump_delta and active_knobs by index;
// write it only while no sample is in flight.
// Reset sets the registers to their defaults and clears the per-knob seen flags;
// the level RAM needs no clearing pass, since an entry is used only once seen.
// When result_ch stalls, the output register holds and one further sample is
// held in the read stage; sample_ch then drops ready until the result is taken.
module knob_scan_smoothing_filter_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ksf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ksf_pkg::CFG_DATA_W-1:0]   cfg_data,
    ksf_in_if.sink                           sample_ch,
    ksf_out_if.source                        result_ch
);

    ksf_pkg::cfg_t cfg_reg;

    logic                            in_fire;
    logic                            move;
    logic [ksf_pkg::LEVEL_W-1:0]     raw_in;

    logic                            s1_valid_reg;
    logic [ksf_pkg::IDX_W-1:0]       s1_idx_reg;
    logic [ksf_pkg::LEVEL_W-1:0]     s1_raw_reg;
    logic                            s1_err_reg;
    logic                            fwd_hit_reg;
    logic [ksf_pkg::LEVEL_W-1:0]     fwd_data_reg;

    logic [ksf_pkg::LEVEL_W-1:0]     rd_data;
    logic [ksf_pkg::LEVEL_W-1:0]     old_level;
    logic [ksf_pkg::LEVEL_W-1:0]     new_level;
    logic                            ram_we;
    logic [ksf_pkg::KNOB_COUNT-1:0]  seen_reg;
    logic [ksf_pkg::KNOB_COUNT-1:0]  seen_next;

    logic                            out_valid_reg;
    logic [ksf_pkg::IDX_W-1:0]       out_knob_reg;
    logic [ksf_pkg::VALUE_W-1:0]     out_value_reg;
    logic                            out_err_reg;
    logic [ksf_pkg::VALUE_W-1:0]     value_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q <= ksf_pkg::ALPHA_RESET;
            cfg_reg.jump_delta <= ksf_pkg::DELTA_RESET;
            cfg_reg.active_knobs <= ksf_pkg::ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (ksf_pkg::cfg_idx_t'(cfg_index))
                ksf_pkg::CFG_ALPHA:  cfg_reg.alpha_q <= cfg_data;
                ksf_pkg::CFG_DELTA:  cfg_reg.jump_delta <= cfg_data;
                ksf_pkg::CFG_ACTIVE: cfg_reg.active_knobs <= cfg_data[ksf_pkg::ACTIVE_W-1:0];
                default:             ;
            endcase
        end
    end

    assign move = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !s1_valid_reg || move;
    assign in_fire = sample_ch.valid && sample_ch.ready;
    assign ram_we = move && !s1_err_reg;

    ksf_raw_map u_raw_map
    (
        .adc_sample (sample_ch.adc_sample),
        .raw        (raw_in)
    );

    ksf_ram #(.DEPTH(ksf_pkg::KNOB_COUNT), .WIDTH(ksf_pkg::LEVEL_W)) u_level_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (new_level),
        .re    (in_fire),
        .raddr (sample_ch.knob_index),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg <= ram_we && (s1_idx_reg == sample_ch.knob_index);
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg <= sample_ch.knob_index;
            s1_raw_reg <= raw_in;
            s1_err_reg <= {1'b0, sample_ch.knob_index} >= cfg_reg.active_knobs;
            fwd_data_reg <= new_level;
        end
    end

    assign old_level = fwd_hit_reg ? fwd_data_reg : rd_data;

    ksf_level_update u_level_update
    (
        .cfg   (cfg_reg),
        .seen  (seen_reg[s1_idx_reg]),
        .raw   (s1_raw_reg),
        .old   (old_level),
        .level (new_level)
    );

    always_comb
    begin
        seen_next = seen_reg;
        if (ram_we)
        begin
            seen_next[s1_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assign value_clamped = (new_level > ksf_pkg::VALUE_MAX)
                           ? ksf_pkg::VALUE_MAX[ksf_pkg::VALUE_W-1:0]
                           : new_level[ksf_pkg::VALUE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_knob_reg <= s1_idx_reg;
            out_value_reg <= s1_err_reg ? '0 : value_clamped;
            out_err_reg <= s1_err_reg;
        end
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.knob_out = out_knob_reg;
    assign result_ch.knob_value = out_value_reg;
    assign result_ch.index_error = out_err_reg;

    a_seen_set: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> seen_reg[$past(s1_idx_reg)])
        else $error("seen flag not set after a level write");

    a_fwd_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ram_we && (s1_idx_reg == sample_ch.knob_index)) |=> fwd_hit_reg)
        else $error("same-knob write missed by the forwarding path");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_err_reg && seen_reg[s1_idx_reg])
        |-> (new_level <= ksf_pkg::LEVEL_MAX))
        else $error("smoothed level out of range");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result_ch.ready) |-> !sample_ch.ready)
        else $error("sample accepted while both stages are full");

    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (move && s1_err_reg) |=> (out_err_reg && (out_value_reg == '0) && $stable(seen_reg)))
        else $error("error request changed state or gave a value");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the knob scan smoothing filter core, with its own level predictor.
module tb_top;

    localparam int IDLE_LIMIT = 2000;
    localparam int SAMPLE_TOP = 4095;

    typedef struct packed {
        logic [ksf_pkg::IDX_W-1:0]   knob_out;
        logic [ksf_pkg::VALUE_W-1:0] knob_value;
        logic                        index_error;
    } knob_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ksf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ksf_pkg::CFG_DATA_W-1:0]  cfg_data;

    ksf_in_if  sample_ch ();
    ksf_out_if result_ch ();

    knob_scan_smoothing_filter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    logic [7:0]                     alpha_m;
    logic [7:0]                     delta_m;
    logic [ksf_pkg::ACTIVE_W-1:0]   active_m;
    logic [ksf_pkg::LEVEL_W-1:0]    level_store [ksf_pkg::KNOB_COUNT];
    logic [ksf_pkg::KNOB_COUNT-1:0] knob_seen;
    int                             last_sample [ksf_pkg::KNOB_COUNT] = '{default: 0};
    knob_result_t                   expected_results [$];
    knob_result_t                   got_result;
    knob_result_t                   want_result;
    int                             error_count = 0;
    int                             send_idle_pct = 0;
    int                             stall_pct = 0;
    int                             hold_left = 0;
    int                             idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic knob_result_t predict_knob_result(
        input logic [ksf_pkg::IDX_W-1:0] idx,
        input logic [ksf_pkg::SAMPLE_W-1:0] smp);
        knob_result_t res;
        int raw;
        int old;
        int diff;
        int lvl;
        res.knob_out = idx;
        res.knob_value = '0;
        res.index_error = 1'b1;
        if (idx >= active_m)
            return res;
        res.index_error = 1'b0;
        raw = ksf_pkg::RAW_TOP_INT
              - ((int'(smp) - int'(ksf_pkg::SAMPLE_LOW)) * ksf_pkg::RAW_TOP_INT)
              / ksf_pkg::SAMPLE_SPAN;
        if (raw < 0)
            raw = 0;
        if (!knob_seen[idx])
        begin
            lvl = raw;
            knob_seen[idx] = 1'b1;
        end
        else
        begin
            old = int'(level_store[idx]);
            diff = (raw > old) ? raw - old : old - raw;
            if (diff > int'(delta_m))
                lvl = raw;
            else if (diff >= 1)
                lvl = (int'(alpha_m) * raw + (256 - int'(alpha_m)) * old) >> 8;
            else
                lvl = old;
        end
        level_store[idx] = ksf_pkg::LEVEL_W'(lvl);
        res.knob_value = ksf_pkg::VALUE_W'((lvl > int'(ksf_pkg::VALUE_MAX))
                                           ? int'(ksf_pkg::VALUE_MAX) : lvl);
        return res;
    endfunction

    task automatic send_sample(input logic [ksf_pkg::IDX_W-1:0] idx,
                               input logic [ksf_pkg::SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.knob_index = idx;
        sample_ch.adc_sample = smp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_knob_result(idx, smp));
        last_sample[idx] = int'(smp);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        sample_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] alpha, input logic [7:0] delta,
                              input logic [ksf_pkg::ACTIVE_W-1:0] active);
        wait_for_results();
        cfg_we = 1'b1;
        cfg_index = ksf_pkg::CFG_ALPHA;
        cfg_data = alpha;
        @(negedge clk);
        cfg_index = ksf_pkg::CFG_DELTA;
        cfg_data = delta;
        @(negedge clk);
        cfg_index = ksf_pkg::CFG_ACTIVE;
        cfg_data = ksf_pkg::CFG_DATA_W'(active);
        @(negedge clk);
        cfg_we = 1'b0;
        alpha_m = alpha;
        delta_m = delta;
        active_m = active;
    endtask

    task automatic set_random_config();
        logic [7:0]                   alpha;
        logic [7:0]                   delta;
        logic [ksf_pkg::ACTIVE_W-1:0] active;
        case ($urandom_range(2))
            0: alpha = 8'd1;
            1: alpha = 8'd255;
            default: alpha = 8'($urandom_range(255, 1));
        endcase
        case ($urandom_range(2))
            0: delta = 8'd0;
            1: delta = 8'd133;
            default: delta = 8'($urandom_range(133, 0));
        endcase
        case ($urandom_range(2))
            0: active = ksf_pkg::ACTIVE_W'(1);
            1: active = ksf_pkg::ACTIVE_W'(ksf_pkg::KNOB_COUNT);
            default: active = ksf_pkg::ACTIVE_W'($urandom_range(ksf_pkg::KNOB_COUNT, 1));
        endcase
        set_config(alpha, delta, active);
    endtask

    task automatic send_random_item();
        int idx;
        int smp;
        int pick;
        if (active_m != 0 && active_m <= ksf_pkg::KNOB_COUNT && $urandom_range(99) < 85)
            idx = $urandom_range(int'(active_m) - 1, 0);
        else
            idx = $urandom_range(ksf_pkg::KNOB_COUNT - 1, 0);
        pick = $urandom_range(99);
        if (pick < 35)
            smp = last_sample[idx] + int'($urandom_range(120)) - 60;
        else if (pick < 60)
            smp = last_sample[idx] + int'($urandom_range(800)) - 400;
        else if (pick < 85)
            smp = $urandom_range(SAMPLE_TOP);
        else
        begin
            case ($urandom_range(4))
                0: smp = 0;
                1: smp = int'(ksf_pkg::SAMPLE_LOW) - 1;
                2: smp = int'(ksf_pkg::SAMPLE_LOW);
                3: smp = int'(ksf_pkg::SAMPLE_LOW) + ksf_pkg::SAMPLE_SPAN;
                default: smp = SAMPLE_TOP;
            endcase
        end
        if (smp < 0)
            smp = 0;
        if (smp > SAMPLE_TOP)
            smp = SAMPLE_TOP;
        send_sample(ksf_pkg::IDX_W'(idx), ksf_pkg::SAMPLE_W'(smp));
    endtask

    task automatic test_default_registers();
        send_sample(4'd0, 12'd0);
        send_sample(4'd0, 12'd4095);
        send_sample(4'd0, 12'd3900);
        send_sample(4'd0, 12'd100);
        send_sample(4'd1, 12'd2000);
        send_sample(4'd1, 12'd2100);
        send_sample(4'd1, 12'd2100);
        send_sample(4'd1, 12'd2100);
        send_sample(4'd1, 12'd99);
        send_sample(4'd15, 12'd4095);
        send_sample(4'd15, 12'd0);
    endtask

    task automatic test_register_extremes();
        set_config(8'd255, 8'd255, ksf_pkg::ACTIVE_W'(16));
        send_sample(4'd2, 12'd4095);
        send_sample(4'd2, 12'd0);
        send_sample(4'd2, 12'd3000);
        // A zero alpha holds the level through every smoothing step.
        set_config(8'd0, 8'd255, ksf_pkg::ACTIVE_W'(16));
        send_sample(4'd2, 12'd2000);
        send_sample(4'd2, 12'd4095);
        set_config(8'd128, 8'd0, ksf_pkg::ACTIVE_W'(16));
        send_sample(4'd3, 12'd1000);
        send_sample(4'd3, 12'd1010);
        // With no knobs in use every index is out of range.
        set_config(8'd64, 8'd10, ksf_pkg::ACTIVE_W'(0));
        send_sample(4'd0, 12'd500);
        send_sample(4'd15, 12'd500);
        set_config(8'd64, 8'd10, ksf_pkg::ACTIVE_W'(1));
        send_sample(4'd0, 12'd500);
        send_sample(4'd1, 12'd500);
        set_config(8'd64, 8'd10, ksf_pkg::ACTIVE_W'(31));
        send_sample(4'd15, 12'd2047);
        set_config(ksf_pkg::ALPHA_RESET, ksf_pkg::DELTA_RESET, ksf_pkg::ACTIVE_RESET);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        wait_for_results();
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
        for (int blk = 0; blk < 3; blk++)
        begin
            set_random_config();
            repeat (count / 3)
                send_random_item();
        end
    endtask

    task automatic test_receiver_hold_off();
        wait_for_results();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (40)
            send_random_item();
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 17;
        stall_pct = 17;
        repeat (15)
            send_random_item();
        wait_for_results();
        repeat (15)
            send_random_item();
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready = 1'b0;
                hold_left--;
            end
            else
                result_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got_result = {result_ch.knob_out, result_ch.knob_value, result_ch.index_error};
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: knob %0d value %0d error %0b",
                         $time, got_result.knob_out, got_result.knob_value,
                         got_result.index_error);
                error_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result !== want_result)
                begin
                    $display("%0t: mismatch, expected %0d %0d %0b, actual %0d %0d %0b",
                             $time, want_result.knob_out, want_result.knob_value,
                             want_result.index_error, got_result.knob_out,
                             got_result.knob_value, got_result.index_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ksf_pkg::CFG_ALPHA;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.knob_index = '0;
        sample_ch.adc_sample = '0;
        alpha_m = ksf_pkg::ALPHA_RESET;
        delta_m = ksf_pkg::DELTA_RESET;
        active_m = ksf_pkg::ACTIVE_RESET;
        knob_seen = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_registers();
        test_register_extremes();
        test_random_traffic(0, 0, 129);
        test_random_traffic(48, 0, 129);
        test_random_traffic(0, 48, 129);
        test_random_traffic(17, 17, 129);
        test_receiver_hold_off();
        test_sender_pause();
        wait_for_results();
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/ksf_pkg.sv
sv/ksf_stream_if.sv
sv/ksf_raw_map.sv
sv/ksf_level_update.sv
sv/ksf_ram.sv
sv/knob_scan_smoothing_filter_core.sv
tb/tb_top.sv
